FILE: hw/rtl/irm_pkg.sv
// Shared types and constants for the IPC rendezvous matcher.
`timescale 1ns / 1ps

package irm_pkg;

  localparam int LEN_W = 13;
  localparam logic [LEN_W-1:0] LEN_LIMIT = 13'd4096;

  localparam logic [1:0] REQ_CALL  = 2'd0;
  localparam logic [1:0] REQ_RECV  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  localparam logic [1:0] OUT_QUEUED    = 2'd0;
  localparam logic [1:0] OUT_DELIVERED = 2'd1;
  localparam logic [1:0] OUT_REPLIED   = 2'd2;
  localparam logic [1:0] OUT_REJECTED  = 2'd3;

  typedef enum logic [1:0] {
    ST_READY,
    ST_SENDING,
    ST_RECEIVING,
    ST_REPLY_BLOCKED
  } ipc_state_t;

  // one task table entry, less the partner id whose width follows the task count
  typedef struct packed {
    ipc_state_t       state;
    logic [LEN_W-1:0] buf_len;
    logic [LEN_W-1:0] msg_len;
    logic             src_flag;
    logic             reply_flag;
  } task_info_t;

endpackage

FILE: hw/rtl/irm_task_table.sv
// Per-task IPC table: two registered read ports, one write port, per-entry valid bits.
`timescale 1ns / 1ps

module irm_task_table
  import irm_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_a_en,
  input  logic [AW-1:0] rd_a_addr,
  output task_info_t    rd_a_info,
  output logic [AW-1:0] rd_a_partner,
  input  logic          rd_b_en,
  input  logic [AW-1:0] rd_b_addr,
  output task_info_t    rd_b_info,
  output logic [AW-1:0] rd_b_partner,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  task_info_t    wr_info,
  input  logic [AW-1:0] wr_partner
);

  typedef struct packed {
    task_info_t    info;
    logic [AW-1:0] partner;
  } word_t;

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] valid;
  word_t            rdata_a;
  word_t            rdata_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{info: wr_info, partner: wr_partner};
    end
  end

  // entries not written since reset read back as all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rdata_a <= valid[rd_a_addr] ? mem[rd_a_addr] : '0;
    end
    if (rd_b_en) begin
      rdata_b <= valid[rd_b_addr] ? mem[rd_b_addr] : '0;
    end
  end

  assign rd_a_info    = rdata_a.info;
  assign rd_a_partner = rdata_a.partner;
  assign rd_b_info    = rdata_b.info;
  assign rd_b_partner = rdata_b.partner;

endmodule

FILE: hw/rtl/ipc_rendezvous_matcher.sv
// Rendezvous matcher top level: request sequencer, sender and receiver queues.
// A request is accepted while busy is low; its result is strobed on done, and
// busy holds off the next request until its write-back is done. No output stall.
// The task table has a single write port: caller and peer entries are written
// in the execute and write-back states, after the caller and peer reads.
// Synchronous reset empties both queues, marks every task entry ready and zero
// through valid bits, and sets the copy limit to 4096; no clearing pass is needed.
`timescale 1ns / 1ps

module ipc_rendezvous_matcher
  import irm_pkg::*;
#(
  parameter int NUM_TASKS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [3:0]       task_id,
  input  logic [7:0]       peer_id,
  input  logic [15:0]      msg_len,
  input  logic [15:0]      buf_len,
  input  logic             src_present,
  input  logic             dst_present,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             done,
  output logic [1:0]       outcome,
  output logic [3:0]       matched_task,
  output logic [LEN_W-1:0] xfer_len,
  output logic             wake_valid,
  output logic [1:0]       caller_state
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int SW = TW + 1;

  typedef enum logic [1:0] {S_IDLE, S_PEER, S_EXEC, S_WB} seq_state_t;

  seq_state_t state;

  logic [LEN_W-1:0] copy_limit;
  logic [LEN_W-1:0] cap;

  // captured request
  logic [1:0]       req_r;
  logic [TW-1:0]    me_r;
  logic             peer_ok_r;
  logic [TW-1:0]    peer_idx_r;
  logic [LEN_W-1:0] mlen_r;
  logic [LEN_W-1:0] blen_r;
  logic             src_r;
  logic             dst_r;
  logic [TW-1:0]    pidx;

  // queues
  logic [TW-1:0] send_q [NUM_TASKS];
  logic [TW-1:0] recv_q [NUM_TASKS];
  logic [TW-1:0] send_rd_ptr;
  logic [TW-1:0] recv_rd_ptr;
  logic [CW-1:0] send_count;
  logic [CW-1:0] recv_count;
  logic [TW-1:0] send_head;
  logic [TW-1:0] recv_head;

  // table ports
  logic          accept;
  logic [TW-1:0] me_in;
  logic [TW-1:0] peer_sel;
  task_info_t    c_info;
  logic [TW-1:0] c_part;
  task_info_t    p_info;
  logic [TW-1:0] p_part;
  logic          tbl_wr_en;
  logic [TW-1:0] tbl_wr_addr;
  task_info_t    tbl_wr_info;
  logic [TW-1:0] tbl_wr_part;

  // execute results
  task_info_t    c1;
  task_info_t    p0;
  task_info_t    cn;
  task_info_t    pn;
  logic [TW-1:0] cn_part;
  logic [TW-1:0] pn_part;
  logic          c_wr;
  logic          p_wr;
  logic          same;
  logic [1:0]    res_outcome;
  logic          res_matched;
  logic [LEN_W-1:0] res_copy;
  logic          res_wake;
  ipc_state_t    res_cstate;
  logic          push_send;
  logic          push_recv;
  logic          pop_send;
  logic          pop_recv;

  // peer entry held for the write-back cycle
  task_info_t    pn_r;
  logic [TW-1:0] pn_part_r;
  logic          p_wr_r;

  logic [3:0]    me_mod;
  logic [SW-1:0] send_wsum;
  logic [SW-1:0] recv_wsum;
  logic [TW-1:0] send_waddr;
  logic [TW-1:0] recv_waddr;

  function automatic logic [LEN_W-1:0] sat_len(input logic [15:0] v);
    return (v > 16'(LEN_LIMIT)) ? LEN_LIMIT : v[LEN_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] copy_amount(
    input logic [LEN_W-1:0] a,
    input logic [LEN_W-1:0] b,
    input logic             s,
    input logic             d,
    input logic [LEN_W-1:0] lim
  );
    logic [LEN_W-1:0] c;
    c = (a < b) ? a : b;
    if (c > lim) c = lim;
    return (s && d) ? c : '0;
  endfunction

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cap       = (copy_limit > LEN_LIMIT) ? LEN_LIMIT : copy_limit;

  // task_id modulo the task count by conditional subtraction of N*8, N*4, N*2, N
  always_comb begin
    me_mod = task_id;
    for (int k = 3; k >= 0; k--) begin
      if (32'(me_mod) >= (NUM_TASKS << k)) begin
        me_mod = me_mod - 4'(NUM_TASKS << k);
      end
    end
  end

  assign me_in = TW'(me_mod);

  always_comb begin
    case (req_r)
      REQ_CALL: peer_sel = recv_head;
      REQ_RECV: peer_sel = send_head;
      default:  peer_sel = peer_idx_r;
    endcase
  end

  irm_task_table #(
    .DEPTH (NUM_TASKS),
    .AW    (TW)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .rd_a_en      (accept),
    .rd_a_addr    (me_in),
    .rd_a_info    (c_info),
    .rd_a_partner (c_part),
    .rd_b_en      (state == S_PEER),
    .rd_b_addr    (peer_sel),
    .rd_b_info    (p_info),
    .rd_b_partner (p_part),
    .wr_en        (tbl_wr_en),
    .wr_addr      (tbl_wr_addr),
    .wr_info      (tbl_wr_info),
    .wr_partner   (tbl_wr_part)
  );

  // caller entry goes in the execute cycle, peer entry in the one after
  always_comb begin
    if (state == S_EXEC) begin
      tbl_wr_en   = c_wr;
      tbl_wr_addr = me_r;
      tbl_wr_info = cn;
      tbl_wr_part = cn_part;
    end else begin
      tbl_wr_en   = (state == S_WB) && p_wr_r;
      tbl_wr_addr = pidx;
      tbl_wr_info = pn_r;
      tbl_wr_part = pn_part_r;
    end
  end

  // a task may match itself: the peer view then includes the caller's earlier updates
  always_comb begin
    same        = (pidx == me_r);
    c1          = c_info;
    p0          = p_info;
    cn          = c_info;
    pn          = p_info;
    cn_part     = c_part;
    pn_part     = p_part;
    c_wr        = 1'b0;
    p_wr        = 1'b0;
    res_outcome = OUT_REJECTED;
    res_matched = 1'b0;
    res_copy    = '0;
    res_wake    = 1'b0;
    res_cstate  = c_info.state;
    push_send   = 1'b0;
    push_recv   = 1'b0;
    pop_send    = 1'b0;
    pop_recv    = 1'b0;
    case (req_r)
      REQ_CALL: begin
        c1.reply_flag = dst_r;
        c1.buf_len    = blen_r;
        c_wr          = 1'b1;
        if (recv_count != '0) begin
          p0          = same ? c1 : p_info;
          res_copy    = copy_amount(mlen_r, p0.buf_len, src_r, p0.src_flag, cap);
          pn          = p0;
          pn.msg_len  = res_copy;
          pn.state    = ST_READY;
          cn          = c1;
          if (same) cn.msg_len = res_copy;
          cn.state    = ST_REPLY_BLOCKED;
          cn_part     = pidx;
          p_wr        = !same;
          pop_recv    = 1'b1;
          res_outcome = OUT_DELIVERED;
          res_matched = 1'b1;
          res_wake    = 1'b1;
          res_cstate  = ST_REPLY_BLOCKED;
        end else begin
          cn          = c1;
          cn.src_flag = src_r;
          cn.msg_len  = mlen_r;
          cn.state    = ST_SENDING;
          push_send   = 1'b1;
          res_outcome = OUT_QUEUED;
          res_cstate  = ST_SENDING;
        end
      end
      REQ_RECV: begin
        c1.src_flag = dst_r;
        c1.buf_len  = blen_r;
        c_wr        = 1'b1;
        if (send_count != '0) begin
          p0          = same ? c1 : p_info;
          res_copy    = copy_amount(p0.msg_len, blen_r, p0.src_flag, dst_r, cap);
          cn          = c1;
          cn.msg_len  = res_copy;
          if (same) begin
            cn.state = ST_REPLY_BLOCKED;
            cn_part  = me_r;
          end
          pn          = p0;
          pn.state    = ST_REPLY_BLOCKED;
          pn_part     = me_r;
          p_wr        = !same;
          pop_send    = 1'b1;
          res_outcome = OUT_DELIVERED;
          res_matched = 1'b1;
          res_cstate  = same ? ST_REPLY_BLOCKED : c_info.state;
        end else begin
          cn          = c1;
          cn.state    = ST_RECEIVING;
          push_recv   = 1'b1;
          res_outcome = OUT_QUEUED;
          res_cstate  = ST_RECEIVING;
        end
      end
      REQ_REPLY: begin
        if (peer_ok_r && p_info.state == ST_REPLY_BLOCKED && p_part == me_r) begin
          res_copy    = copy_amount(mlen_r, p_info.buf_len, src_r, p_info.reply_flag, cap);
          pn          = p_info;
          pn.msg_len  = res_copy;
          pn.state    = ST_READY;
          p_wr        = 1'b1;
          res_outcome = OUT_REPLIED;
          res_matched = 1'b1;
          res_wake    = 1'b1;
          res_cstate  = same ? ST_READY : c_info.state;
        end
      end
      default: begin
      end
    endcase
  end

  // push slot: (rd_ptr + count) wrapped at the task count
  always_comb begin
    send_wsum = SW'(send_rd_ptr) + SW'(send_count);
    recv_wsum = SW'(recv_rd_ptr) + SW'(recv_count);
    if (32'(send_wsum) >= NUM_TASKS) send_wsum = send_wsum - SW'(NUM_TASKS);
    if (32'(recv_wsum) >= NUM_TASKS) recv_wsum = recv_wsum - SW'(NUM_TASKS);
    send_waddr = send_wsum[TW-1:0];
    recv_waddr = recv_wsum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      send_head <= send_q[send_rd_ptr];
      recv_head <= recv_q[recv_rd_ptr];
    end
    if (state == S_EXEC) begin
      if (push_send && 32'(send_count) < NUM_TASKS) send_q[send_waddr] <= me_r;
      if (push_recv && 32'(recv_count) < NUM_TASKS) recv_q[recv_waddr] <= me_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_rd_ptr <= '0;
      recv_rd_ptr <= '0;
      send_count  <= '0;
      recv_count  <= '0;
    end else if (state == S_EXEC) begin
      if (pop_send) begin
        send_rd_ptr <= (send_rd_ptr == TW'(NUM_TASKS - 1)) ? '0 : send_rd_ptr + 1'b1;
        send_count  <= send_count - 1'b1;
      end else if (push_send && 32'(send_count) < NUM_TASKS) begin
        send_count  <= send_count + 1'b1;
      end
      if (pop_recv) begin
        recv_rd_ptr <= (recv_rd_ptr == TW'(NUM_TASKS - 1)) ? '0 : recv_rd_ptr + 1'b1;
        recv_count  <= recv_count - 1'b1;
      end else if (push_recv && 32'(recv_count) < NUM_TASKS) begin
        recv_count  <= recv_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_limit <= LEN_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      copy_limit <= cfg_data;
    end
  end

  // request capture and write-back payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_type;
      me_r       <= me_in;
      peer_ok_r  <= (32'(peer_id) < NUM_TASKS);
      peer_idx_r <= TW'(peer_id);
      mlen_r     <= sat_len(msg_len);
      blen_r     <= sat_len(buf_len);
      src_r      <= src_present;
      dst_r      <= dst_present;
    end
    if (state == S_PEER) begin
      pidx <= peer_sel;
    end
    if (state == S_EXEC) begin
      pn_r      <= pn;
      pn_part_r <= pn_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      p_wr_r <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) state <= S_PEER;
        end
        S_PEER: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          p_wr_r       <= p_wr;
          done         <= 1'b1;
          outcome      <= res_outcome;
          matched_task <= res_matched ? 4'(pidx) : 4'd0;
          xfer_len     <= res_copy;
          wake_valid   <= res_wake;
          caller_state <= res_cstate;
          state        <= S_WB;
        end
        S_WB: begin
          p_wr_r <= 1'b0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the IPC rendezvous matcher: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
  import irm_pkg::*;

  localparam int TASKS = 16;
  localparam logic [1:0] REQ_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  task_no;
    logic [7:0]  peer;
    logic [15:0] mlen;
    logic [15:0] blen;
    logic        src;
    logic        dst;
  } request_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [3:0]       matched;
    logic [LEN_W-1:0] copy;
    logic             wake;
    ipc_state_t       cstate;
  } verdict_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  localparam verdict_t REJ_READY = '{OUT_REJECTED, 4'd0, 13'd0, 1'b0, ST_READY};
  localparam verdict_t Q_SEND    = '{OUT_QUEUED, 4'd0, 13'd0, 1'b0, ST_SENDING};
  localparam verdict_t Q_RECV    = '{OUT_QUEUED, 4'd0, 13'd0, 1'b0, ST_RECEIVING};
  localparam verdict_t DELIV_MAX = '{OUT_DELIVERED, 4'd1, 13'd4096, 1'b0, ST_READY};
  localparam verdict_t PREDICTED = '0;

  // kind, task, peer, msg_len, buf_len, src, dst | typed | expected
  localparam dir_row_t DIRECTED [24] = '{
    '{'{REQ_REPLY, 4'd0,  8'd1,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_UNDEF, 4'd15, 8'd255, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_REPLY, 4'd0,  8'd255, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_CALL,  4'd1,  8'd0,   16'hFFFF,  16'hFFFF,  1'b1, 1'b1}, 1'b1, Q_SEND},
    '{'{REQ_RECV,  4'd2,  8'd0,   16'd0,     16'hFFFF,  1'b0, 1'b1}, 1'b1, DELIV_MAX},
    '{'{REQ_REPLY, 4'd2,  8'd1,   16'd0,     16'd0,     1'b1, 1'b0}, 1'b0, PREDICTED},
    '{'{REQ_RECV,  4'd3,  8'd0,   16'd0,     16'd100,   1'b1, 1'b1}, 1'b1, Q_RECV},
    '{'{REQ_CALL,  4'd4,  8'd0,   16'd50,    16'd20,    1'b1, 1'b1}, 1'b0, PREDICTED},
    // partner differs
    '{'{REQ_REPLY, 4'd5,  8'd4,   16'd10,    16'd0,     1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_REPLY, 4'd3,  8'd4,   16'd1000,  16'd0,     1'b1, 1'b1}, 1'b0, PREDICTED},
    // peer no longer reply blocked
    '{'{REQ_REPLY, 4'd3,  8'd4,   16'd1000,  16'd0,     1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_CALL,  4'd6,  8'd0,   16'd300,   16'd4097,  1'b0, 1'b1}, 1'b1, Q_SEND},
    '{'{REQ_RECV,  4'd7,  8'd0,   16'd0,     16'd500,   1'b1, 1'b1}, 1'b0, PREDICTED},
    // peer id just past the task table
    '{'{REQ_REPLY, 4'd7,  8'd16,  16'd5,     16'd0,     1'b1, 1'b1}, 1'b1, REJ_READY},
    '{'{REQ_REPLY, 4'd7,  8'd6,   16'd4097,  16'd0,     1'b1, 1'b1}, 1'b0, PREDICTED},
    '{'{REQ_RECV,  4'd15, 8'd0,   16'd0,     16'd4096,  1'b1, 1'b0}, 1'b1, Q_RECV},
    '{'{REQ_CALL,  4'd14, 8'd0,   16'd4096,  16'd1,     1'b1, 1'b1}, 1'b0, PREDICTED},
    '{'{REQ_REPLY, 4'd15, 8'd14,  16'd2,     16'd0,     1'b1, 1'b1}, 1'b0, PREDICTED},
    // same task queued twice, then drained twice
    '{'{REQ_CALL,  4'd0,  8'd0,   16'd8,     16'd8,     1'b1, 1'b1}, 1'b1, Q_SEND},
    '{'{REQ_CALL,  4'd0,  8'd0,   16'd9,     16'd9,     1'b1, 1'b1}, 1'b1, Q_SEND},
    '{'{REQ_RECV,  4'd9,  8'd0,   16'd0,     16'd64,    1'b1, 1'b1}, 1'b0, PREDICTED},
    '{'{REQ_RECV,  4'd9,  8'd0,   16'd0,     16'd64,    1'b1, 1'b1}, 1'b0, PREDICTED},
    // a task matching itself
    '{'{REQ_RECV,  4'd10, 8'd0,   16'd0,     16'd32,    1'b1, 1'b1}, 1'b1, Q_RECV},
    '{'{REQ_CALL,  4'd10, 8'd0,   16'd16,    16'd16,    1'b1, 1'b1}, 1'b0, PREDICTED}
  };

  localparam logic [LEN_W-1:0] PHASE_CAP [5] = '{13'd0, 13'd8191, 13'd0, 13'd4096, 13'd37};
  localparam int PHASE_IDLE [5] = '{35, 35, 81, 0, 0};
  localparam int PHASE_ITEMS = 120;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type = '0;
  logic [3:0]       task_id = '0;
  logic [7:0]       peer_id = '0;
  logic [15:0]      msg_len = '0;
  logic [15:0]      buf_len = '0;
  logic             src_present = 1'b0;
  logic             dst_present = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             done;
  logic [1:0]       outcome;
  logic [3:0]       matched_task;
  logic [LEN_W-1:0] xfer_len;
  logic             wake_valid;
  logic [1:0]       caller_state;

  // predictor state
  ipc_state_t       tsk_state [TASKS];
  logic [LEN_W-1:0] tsk_buf [TASKS];
  logic [LEN_W-1:0] tsk_msg [TASKS];
  logic             tsk_src [TASKS];
  logic             tsk_rflag [TASKS];
  logic [3:0]       tsk_partner [TASKS];
  logic [3:0]       senders [$];
  logic [3:0]       receivers [$];
  logic [LEN_W-1:0] copy_cap;

  verdict_t pending [$];
  verdict_t want_now;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_delivered = 0;
  int n_replied = 0;
  int n_rejected = 0;
  logic [LEN_W-1:0] rand_cap;

  ipc_rendezvous_matcher #(.NUM_TASKS(TASKS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .task_id      (task_id),
    .peer_id      (peer_id),
    .msg_len      (msg_len),
    .buf_len      (buf_len),
    .src_present  (src_present),
    .dst_present  (dst_present),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .outcome      (outcome),
    .matched_task (matched_task),
    .xfer_len     (xfer_len),
    .wake_valid   (wake_valid),
    .caller_state (caller_state)
  );

  always #5 clk = ~clk;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [15:0] x);
    return (x > 16'd4096) ? LEN_LIMIT : x[LEN_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] copy_amount(input logic [LEN_W-1:0] a,
                                                   input logic [LEN_W-1:0] b,
                                                   input logic s, input logic d);
    logic [LEN_W-1:0] c, lim;
    lim = (copy_cap > LEN_LIMIT) ? LEN_LIMIT : copy_cap;
    c = (a < b) ? a : b;
    if (c > lim) c = lim;
    return (s && d) ? c : '0;
  endfunction

  // applies one request to the task table and queues, returns its result
  function automatic verdict_t rendezvous(input request_t rq);
    verdict_t v;
    logic [3:0] me, other;
    logic [LEN_W-1:0] ml, bl;
    v = '{OUT_REJECTED, 4'd0, 13'd0, 1'b0, ST_READY};
    me = rq.task_no;
    ml = clamp_len(rq.mlen);
    bl = clamp_len(rq.blen);
    case (rq.kind)
      REQ_CALL: begin
        tsk_rflag[me] = rq.dst;
        tsk_buf[me] = bl;
        if (receivers.size() != 0) begin
          other = receivers.pop_front();
          v.copy = copy_amount(ml, tsk_buf[other], rq.src, tsk_src[other]);
          tsk_msg[other] = v.copy;
          tsk_partner[me] = other;
          tsk_state[other] = ST_READY;
          tsk_state[me] = ST_REPLY_BLOCKED;
          v.outcome = OUT_DELIVERED;
          v.matched = other;
          v.wake = 1'b1;
        end else begin
          tsk_src[me] = rq.src;
          tsk_msg[me] = ml;
          tsk_state[me] = ST_SENDING;
          if (senders.size() < TASKS) senders.push_back(me);
          v.outcome = OUT_QUEUED;
        end
      end
      REQ_RECV: begin
        tsk_src[me] = rq.dst;
        tsk_buf[me] = bl;
        if (senders.size() != 0) begin
          other = senders.pop_front();
          v.copy = copy_amount(tsk_msg[other], bl, tsk_src[other], rq.dst);
          tsk_msg[me] = v.copy;
          tsk_partner[other] = me;
          tsk_state[other] = ST_REPLY_BLOCKED;
          v.outcome = OUT_DELIVERED;
          v.matched = other;
        end else begin
          tsk_state[me] = ST_RECEIVING;
          if (receivers.size() < TASKS) receivers.push_back(me);
          v.outcome = OUT_QUEUED;
        end
      end
      REQ_REPLY: begin
        other = rq.peer[3:0];
        if (rq.peer < TASKS && tsk_state[other] == ST_REPLY_BLOCKED &&
            tsk_partner[other] == me) begin
          v.copy = copy_amount(ml, tsk_buf[other], rq.src, tsk_rflag[other]);
          tsk_msg[other] = v.copy;
          tsk_state[other] = ST_READY;
          v.outcome = OUT_REPLIED;
          v.matched = other;
          v.wake = 1'b1;
        end
      end
      default: ;
    endcase
    v.cstate = tsk_state[me];
    return v;
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(5))
      0: return 16'($urandom_range(64));
      1: return 16'($urandom_range(4096));
      2: return 16'($urandom_range(4100, 4090));
      3: return 16'($urandom_range(16'hFFFF));
      4: return 16'hFFFF;
      default: return 16'($urandom_range(512));
    endcase
  endfunction

  // mostly well-formed traffic: idle tasks call or receive, partners reply
  function automatic request_t random_request();
    request_t rq;
    logic [3:0] cand [$];
    int pick, idx;
    pick = $urandom_range(99);
    rq.task_no = 4'($urandom_range(15));
    rq.peer = 8'($urandom_range(255));
    rq.mlen = pick_len();
    rq.blen = pick_len();
    rq.src = ($urandom_range(99) < 85);
    rq.dst = ($urandom_range(99) < 85);
    if (pick < 3) begin
      rq.kind = REQ_UNDEF;
    end else if (pick < 66) begin
      rq.kind = (pick < 35) ? REQ_CALL : REQ_RECV;
      for (int t = 0; t < TASKS; t++)
        if (tsk_state[t] == ST_READY) cand.push_back(4'(t));
      if (cand.size() != 0 && $urandom_range(99) < 85)
        rq.task_no = cand[$urandom_range(cand.size() - 1)];
    end else begin
      rq.kind = REQ_REPLY;
      for (int t = 0; t < TASKS; t++)
        if (tsk_state[t] == ST_REPLY_BLOCKED) cand.push_back(4'(t));
      if (cand.size() != 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(cand.size() - 1);
        rq.peer = {4'd0, cand[idx]};
        rq.task_no = tsk_partner[cand[idx]];
      end else if ($urandom_range(1) == 0) begin
        rq.peer = 8'($urandom_range(15));
      end
    end
    return rq;
  endfunction

  task automatic issue(input request_t rq, input int idle_pct, input logic typed,
                       input verdict_t want);
    int gap;
    verdict_t got;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= rq.kind;
    task_id     <= rq.task_no;
    peer_id     <= rq.peer;
    msg_len     <= rq.mlen;
    buf_len     <= rq.blen;
    src_present <= rq.src;
    dst_present <= rq.dst;
    do @(posedge clk); while (busy);
    got = rendezvous(rq);
    pending.push_back(typed ? want : got);
    n_sent++;
  endtask

  // only once every result is back and the block has settled
  task automatic write_cap(input logic [LEN_W-1:0] val);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    copy_cap = val;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding, outcome", outcome, -1);
      end else begin
        want_now = pending.pop_front();
        n_checked++;
        if (outcome !== want_now.outcome)
          report_mismatch("outcome", outcome, want_now.outcome);
        if (matched_task !== want_now.matched)
          report_mismatch("matched_task", matched_task, want_now.matched);
        if (xfer_len !== want_now.copy)
          report_mismatch("xfer_len", xfer_len, want_now.copy);
        if (wake_valid !== want_now.wake)
          report_mismatch("wake_valid", wake_valid, want_now.wake);
        if (caller_state !== want_now.cstate)
          report_mismatch("caller_state", caller_state, want_now.cstate);
        case (outcome)
          OUT_DELIVERED: n_delivered++;
          OUT_REPLIED:   n_replied++;
          OUT_REJECTED:  n_rejected++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    for (int t = 0; t < TASKS; t++) begin
      tsk_state[t] = ST_READY;
      tsk_buf[t] = '0;
      tsk_msg[t] = '0;
      tsk_src[t] = 1'b0;
      tsk_rflag[t] = 1'b0;
      tsk_partner[t] = '0;
    end
    copy_cap = LEN_LIMIT;
    rand_cap = 13'($urandom_range(4095, 1));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      issue(DIRECTED[i].rq, 0, DIRECTED[i].typed, DIRECTED[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      write_cap((ph == 2) ? rand_cap : PHASE_CAP[ph]);
      repeat (PHASE_ITEMS) issue(random_request(), PHASE_IDLE[ph], 1'b0, PREDICTED);
    end

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests issued, %0d results checked: %0d delivered, %0d replies, %0d rejected",
             n_sent, n_checked, n_delivered, n_replied, n_rejected);
    $display("copy limits 4096, 0, 8191, %0d, 4096, 37; sender gaps 35%%, 81%%, none", rand_cap);
    if (errors == 0 && pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/irm_pkg.sv
hw/rtl/irm_task_table.sv
hw/rtl/ipc_rendezvous_matcher.sv
sim/tb.sv
